@@ hw/rtl/acsc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acsc_pkg
// Types and constants shared by the accumulator CPU execute block.
// ----------------------------------------------------------------------------
package acsc_pkg;

  localparam int unsigned XLEN     = 32;
  localparam int unsigned OPC_W    = 8;
  localparam int unsigned LADDR_W  = 12;
  localparam int unsigned SHAMT_W  = 5;

  // request kinds
  localparam logic KIND_PRELOAD = 1'b0;
  localparam logic KIND_EXEC    = 1'b1;

  typedef enum logic [OPC_W-1:0] {
    OP_LDC    = 8'd0,
    OP_ADC    = 8'd1,
    OP_LDL    = 8'd2,
    OP_STL    = 8'd3,
    OP_LDNL   = 8'd4,
    OP_STNL   = 8'd5,
    OP_ADD    = 8'd6,
    OP_SUB    = 8'd7,
    OP_SHL    = 8'd8,
    OP_SHR    = 8'd9,
    OP_ADJ    = 8'd10,
    OP_A2SP   = 8'd11,
    OP_SP2A   = 8'd12,
    OP_CALL   = 8'd13,
    OP_RETURN = 8'd14,
    OP_BRZ    = 8'd15,
    OP_BRLZ   = 8'd16,
    OP_BR     = 8'd17,
    OP_HALT   = 8'd18
  } op_e;

  typedef enum logic [1:0] {
    ACC_NONE  = 2'd0,
    ACC_READ  = 2'd1,
    ACC_WRITE = 2'd2
  } access_e;

  typedef struct packed {
    logic                      kind;
    logic signed [XLEN-1:0]    word;
    logic [LADDR_W-1:0]        load_address;
  } in_item_t;

  typedef struct packed {
    logic signed [XLEN-1:0]    pc;
    logic signed [XLEN-1:0]    sp;
    logic signed [XLEN-1:0]    reg_a;
    logic signed [XLEN-1:0]    reg_b;
    logic [1:0]                access;
    logic [LADDR_W-1:0]        access_address;
    logic signed [XLEN-1:0]    old_value;
    logic signed [XLEN-1:0]    new_value;
    logic                      halted;
    logic                      fault;
  } out_item_t;

  // architectural registers
  typedef struct packed {
    logic [XLEN-1:0] pc;
    logic [XLEN-1:0] sp;
    logic [XLEN-1:0] a;
    logic [XLEN-1:0] b;
  } regs_t;

  // request held while its memory read is in flight
  typedef struct packed {
    logic             kind;
    logic [OPC_W-1:0] opc;
    logic [XLEN-1:0]  off;
    logic [XLEN-1:0]  word;
    logic [XLEN-1:0]  addr;
    logic             addr_ok;
  } issue_t;

  // write-back towards the data memory
  typedef struct packed {
    logic            en;
    logic [XLEN-1:0] data;
  } mem_wr_t;

endpackage

@@ hw/rtl/acsc_dmem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acsc_dmem
// Data memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module acsc_dmem import acsc_pkg::*; #(
  parameter int unsigned MEM_WORDS = 4096,
  parameter int unsigned AW        = $clog2(MEM_WORDS)
) (
  input  logic            clk_i,
  input  logic            re_i,
  input  logic [AW-1:0]   raddr_i,
  output logic [XLEN-1:0] rdata_o,
  input  logic            we_i,
  input  logic [AW-1:0]   waddr_i,
  input  logic [XLEN-1:0] wdata_i
);

  logic [XLEN-1:0] mem_q [MEM_WORDS];
  logic [XLEN-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // hold the read data until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/acsc_exec.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acsc_exec
// Completes one request: register update, memory write-back and result word.
// ----------------------------------------------------------------------------
module acsc_exec import acsc_pkg::*; (
  input  issue_t          iss_i,
  input  regs_t           regs_i,
  input  logic [XLEN-1:0] rdata_i,
  output regs_t           regs_o,
  output mem_wr_t         wr_o,
  output out_item_t       res_o
);

  op_e             op;
  logic [XLEN-1:0] pc_br;
  logic            halted;
  logic            fault;
  logic [1:0]      access;
  logic [XLEN-1:0] old_value;
  logic [XLEN-1:0] new_value;
  logic            shamt_big;

  assign op        = op_e'(iss_i.opc);
  assign shamt_big = |regs_i.a[XLEN-1:SHAMT_W];

  always_comb begin
    regs_o    = regs_i;
    wr_o.en   = 1'b0;
    wr_o.data = regs_i.a;
    halted    = 1'b0;
    fault     = 1'b0;
    access    = ACC_NONE;
    old_value = '0;
    new_value = '0;
    pc_br     = regs_i.pc;

    if (iss_i.kind == KIND_PRELOAD) begin
      if (iss_i.addr_ok) begin
        access    = ACC_WRITE;
        old_value = rdata_i;
        new_value = iss_i.word;
        wr_o.en   = 1'b1;
        wr_o.data = iss_i.word;
      end else begin
        fault = 1'b1;
      end
    end else begin
      unique case (op)
        OP_LDC: begin
          regs_o.b = regs_i.a;
          regs_o.a = iss_i.off;
        end
        OP_ADC:  regs_o.a = regs_i.a + iss_i.off;
        OP_LDL, OP_LDNL: begin
          if (!iss_i.addr_ok) begin
            fault = 1'b1;
          end else begin
            if (op == OP_LDL) begin
              regs_o.b = regs_i.a;
            end
            regs_o.a  = rdata_i;
            access    = ACC_READ;
            new_value = rdata_i;
          end
        end
        OP_STL: begin
          if (!iss_i.addr_ok) begin
            fault = 1'b1;
          end else begin
            access    = ACC_WRITE;
            old_value = rdata_i;
            new_value = regs_i.a;
            wr_o.en   = 1'b1;
            wr_o.data = regs_i.a;
            regs_o.a  = regs_i.b;
          end
        end
        OP_STNL: begin
          if (!iss_i.addr_ok) begin
            fault = 1'b1;
          end else begin
            access    = ACC_WRITE;
            old_value = rdata_i;
            new_value = regs_i.b;
            wr_o.en   = 1'b1;
            wr_o.data = regs_i.b;
          end
        end
        OP_ADD:  regs_o.a = regs_i.b + regs_i.a;
        OP_SUB:  regs_o.a = regs_i.b - regs_i.a;
        OP_SHL: begin
          regs_o.a = shamt_big ? '0 : (regs_i.b << regs_i.a[SHAMT_W-1:0]);
        end
        OP_SHR: begin
          regs_o.a = shamt_big ? {XLEN{regs_i.b[XLEN-1]}}
                               : XLEN'($signed(regs_i.b) >>> regs_i.a[SHAMT_W-1:0]);
        end
        OP_ADJ:  regs_o.sp = regs_i.sp + iss_i.off;
        OP_A2SP: begin
          regs_o.sp = regs_i.a;
          regs_o.a  = regs_i.b;
        end
        OP_SP2A: begin
          regs_o.b = regs_i.a;
          regs_o.a = regs_i.sp;
        end
        OP_CALL: begin
          regs_o.b = regs_i.a;
          regs_o.a = regs_i.pc;
          pc_br    = regs_i.pc + iss_i.off;
        end
        OP_RETURN: begin
          pc_br    = regs_i.a;
          regs_o.a = regs_i.b;
        end
        OP_BRZ: begin
          if (regs_i.a == '0) begin
            pc_br = regs_i.pc + iss_i.off;
          end
        end
        OP_BRLZ: begin
          if (regs_i.a[XLEN-1]) begin
            pc_br = regs_i.pc + iss_i.off;
          end
        end
        OP_BR:   pc_br = regs_i.pc + iss_i.off;
        OP_HALT: halted = 1'b1;
        default: ;
      endcase
      regs_o.pc = halted ? regs_i.pc : pc_br + XLEN'(1);
    end
  end

  always_comb begin
    res_o.pc             = regs_o.pc;
    res_o.sp             = regs_o.sp;
    res_o.reg_a          = regs_o.a;
    res_o.reg_b          = regs_o.b;
    res_o.access         = access;
    res_o.access_address = (access == ACC_NONE) ? '0 : iss_i.addr[LADDR_W-1:0];
    res_o.old_value      = old_value;
    res_o.new_value      = new_value;
    res_o.halted         = halted;
    res_o.fault          = fault;
  end

endmodule

@@ hw/rtl/accumulator_stack_cpu_execute.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accumulator_stack_cpu_execute
// Execute stage of a two-register accumulator machine with a data memory.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+------------
//   in      | input     | in_valid_i / in_stall_o    | in_item_t
//   out     | output    | out_valid_o / out_stall_i  | out_item_t
//
// The memory read is issued at acceptance; the request completes once the read
// data is back and the output register can take the result. The next request is
// taken after that, since its address depends on A and SP.
// Reset clears PC, SP, A, B and all valid flags; the data memory is not cleared.
// A stalled result sits in the output register while the next request is
// accepted and its memory read issued.
// ----------------------------------------------------------------------------
module accumulator_stack_cpu_execute import acsc_pkg::*; #(
  parameter int unsigned MEM_WORDS = 4096
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  localparam int unsigned     AW        = $clog2(MEM_WORDS);
  localparam logic [XLEN-1:0] MEM_LIMIT = XLEN'(MEM_WORDS);

  logic      in_fire;
  logic      done;
  logic      iss_valid_q, iss_valid_d;
  issue_t    iss_q, iss_d;
  regs_t     regs_q, regs_next;
  logic      out_valid_q, out_valid_d;
  out_item_t out_q, res;
  mem_wr_t   wr;

  logic [XLEN-1:0] rdata;
  logic [XLEN-1:0] off;
  logic [XLEN-1:0] base;
  op_e             op;

  assign in_stall_o = iss_valid_q;
  assign in_fire    = in_valid_i && !iss_valid_q;
  assign done       = iss_valid_q && (!out_valid_q || !out_stall_i);

  // address generation for the request being accepted
  assign op   = op_e'(in_data_i.word[OPC_W-1:0]);
  assign off  = {{OPC_W{in_data_i.word[XLEN-1]}}, in_data_i.word[XLEN-1:OPC_W]};
  assign base = (op == OP_LDNL || op == OP_STNL) ? regs_q.a : regs_q.sp;

  always_comb begin
    iss_d.kind = in_data_i.kind;
    iss_d.opc  = in_data_i.word[OPC_W-1:0];
    iss_d.off  = off;
    iss_d.word = in_data_i.word;
    if (in_data_i.kind == KIND_PRELOAD) begin
      iss_d.addr = XLEN'(in_data_i.load_address);
    end else begin
      iss_d.addr = base + off;
    end
    // negative sums are large unsigned values and fail too
    iss_d.addr_ok = iss_d.addr < MEM_LIMIT;
  end

  always_comb begin
    iss_valid_d = iss_valid_q;
    if (in_fire) begin
      iss_valid_d = 1'b1;
    end else if (done) begin
      iss_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (done) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  acsc_dmem #(
    .MEM_WORDS (MEM_WORDS),
    .AW        (AW)
  ) u_dmem (
    .clk_i   (clk_i),
    .re_i    (in_fire && iss_d.addr_ok),
    .raddr_i (iss_d.addr[AW-1:0]),
    .rdata_o (rdata),
    .we_i    (done && wr.en),
    .waddr_i (iss_q.addr[AW-1:0]),
    .wdata_i (wr.data)
  );

  acsc_exec u_exec (
    .iss_i   (iss_q),
    .regs_i  (regs_q),
    .rdata_i (rdata),
    .regs_o  (regs_next),
    .wr_o    (wr),
    .res_o   (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iss_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      regs_q      <= '0;
    end else begin
      iss_valid_q <= iss_valid_d;
      out_valid_q <= out_valid_d;
      if (done) begin
        regs_q <= regs_next;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      iss_q <= iss_d;
    end
    if (done) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
